/* hdl/padded_integer_to_text_defines.svh */
// Assertion helpers used by padded_integer_to_text.
`ifndef PADDED_INTEGER_TO_TEXT_DEFINES_SVH
`define PADDED_INTEGER_TO_TEXT_DEFINES_SVH

// Check a consequence in the same cycle.
`define PTT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the next cycle.
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ptt_pkg.sv */
package ptt_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int WIDTH_W     = 7;
  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int KIND_W      = 3;
  localparam int DIGIT_W     = 4;
  localparam int DIGITS_MAX  = 32;
  localparam int COUNT_W     = $clog2(DIGITS_MAX + 1);
  localparam int DEC_BASE    = 10;
  localparam int RECIP_SHIFT = 35;
  localparam int QUOT_W      = 2 * VALUE_W - RECIP_SHIFT;

  localparam logic [VALUE_W-1:0] RECIP_DEC = 32'hCCCC_CCCD;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

  typedef enum logic [KIND_W-1:0] {
    KIND_SDEC = 3'd0,
    KIND_UDEC = 3'd1,
    KIND_HEX  = 3'd2,
    KIND_OCT  = 3'd3,
    KIND_BIN  = 3'd4,
    KIND_CHAR = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_HEX,
    RADIX_OCT,
    RADIX_BIN
  } radix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_PREP,
    ST_PAD_LEAD,
    ST_SIGN,
    ST_CHAR,
    ST_DIGITS,
    ST_PAD_TRAIL
  } state_t;

  typedef struct packed {
    logic               start;
    radix_t             radix;
    logic [VALUE_W-1:0] mag;
  } dig_req_t;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic [DIGIT_W-1:0] digit;
  } dig_rsp_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [DIGIT_W-1:0] digit;
  } stack_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(DEC_BASE)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_UPPER_A + CHAR_W'(d) - CHAR_W'(DEC_BASE);
    end
    return c;
  endfunction

endpackage

/* hdl/ptt_if.sv */
interface ptt_operand_if;
  import ptt_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [VALUE_W-1:0]  value;
  logic [WIDTH_W-1:0]  field_width;
  logic                pad_with_zero;
  logic                align_left;

  modport source (
    output valid, kind, value, field_width, pad_with_zero, align_left,
    input  ready
  );

  modport sink (
    input  valid, kind, value, field_width, pad_with_zero, align_left,
    output ready
  );
endinterface

interface ptt_text_if;
  import ptt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              last_char;

  modport source (
    output valid, text_char, last_char,
    input  ready
  );

  modport sink (
    input  valid, text_char, last_char,
    output ready
  );
endinterface

/* hdl/ptt_digit_unit.sv */
module ptt_digit_unit (
  input  logic              clk,
  input  logic              rst,
  input  ptt_pkg::dig_req_t req,
  output ptt_pkg::dig_rsp_t rsp
);
  import ptt_pkg::*;

  logic                   busy;
  logic                   phase;
  radix_t                 radix;
  logic [VALUE_W-1:0]     mag;
  logic [VALUE_W-1:0]     mag_next;
  logic [2*VALUE_W-1:0]   prod;
  logic [QUOT_W-1:0]      quot;
  logic [VALUE_W-1:0]     times_ten;
  logic [VALUE_W-1:0]     rem;
  logic [DIGIT_W-1:0]     digit;
  logic                   step;

  assign quot      = prod[2*VALUE_W-1:RECIP_SHIFT];
  assign times_ten = VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0});
  assign rem       = mag - times_ten;
  assign step      = busy && ((radix != RADIX_DEC) || phase);

  always_comb begin
    unique case (radix)
      RADIX_DEC: begin
        digit    = rem[DIGIT_W-1:0];
        mag_next = VALUE_W'(quot);
      end
      RADIX_HEX: begin
        digit    = mag[3:0];
        mag_next = mag >> 4;
      end
      RADIX_OCT: begin
        digit    = {1'b0, mag[2:0]};
        mag_next = mag >> 3;
      end
      RADIX_BIN: begin
        digit    = {3'b000, mag[0]};
        mag_next = mag >> 1;
      end
      default: begin
        digit    = '0;
        mag_next = '0;
      end
    endcase
  end

  assign rsp.valid = step;
  assign rsp.last  = step && (mag_next == '0);
  assign rsp.digit = digit;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (req.start) begin
      busy  <= 1'b1;
      phase <= 1'b0;
    end else if (busy) begin
      if (step) begin
        phase <= 1'b0;
        if (mag_next == '0) begin
          busy <= 1'b0;
        end
      end else begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mag   <= req.mag;
      radix <= req.radix;
    end else if (step) begin
      mag <= mag_next;
    end
    if (busy && !step) begin
      prod <= (2*VALUE_W)'(mag) * (2*VALUE_W)'(RECIP_DEC);
    end
  end

endmodule

/* hdl/ptt_stack.sv */
module ptt_stack (
  input  logic                       clk,
  input  logic                       rst,
  input  ptt_pkg::stack_ctl_t        ctl,
  output logic [ptt_pkg::DIGIT_W-1:0] top,
  output logic [ptt_pkg::COUNT_W-1:0] count
);
  import ptt_pkg::*;

  logic [DIGIT_W-1:0] entries [DIGITS_MAX];

  assign top = entries[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + COUNT_W'(1);
    end else if (ctl.pop) begin
      count <= count - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entries[0] <= ctl.digit;
      for (int i = 1; i < DIGITS_MAX; i++) begin
        entries[i] <= entries[i-1];
      end
    end else if (ctl.pop) begin
      for (int i = 0; i < DIGITS_MAX - 1; i++) begin
        entries[i] <= entries[i+1];
      end
    end
  end

endmodule

/* hdl/padded_integer_to_text.sv */
// Integer to ASCII text converter with field padding.
// operand: one transfer carries kind, value, field_width, pad_with_zero and
//   align_left. ready is high only while the block is idle.
// text: one transfer per output character, most significant first;
//   last_char marks the final character of the item. Kinds 6 and 7 give
//   no characters at all.
// Digits come from one shared digit unit: decimal does a reciprocal multiply,
//   then a remainder, per digit; hex, octal and binary shift each digit out.
//   A digit stack reverses them, then the ST_PREP state sizes the padding.
// Then one character per cycle leaves through the output register while
//   the receiver is ready; the next operand is taken the cycle after the
//   last character is loaded.
// A stalled receiver holds the output register and pauses emission; no
//   character is lost or repeated.
// Reset (rst, synchronous) returns the block to idle with an empty
//   digit stack and the output register empty.
`include "padded_integer_to_text_defines.svh"

module padded_integer_to_text (
  input  logic          clk,
  input  logic          rst,
  ptt_operand_if.sink   operand,
  ptt_text_if.source    text
);
  import ptt_pkg::*;

  state_t               state;
  state_t               state_next;
  state_t               first_text;

  dig_req_t             dig_req;
  dig_rsp_t             dig_rsp;
  stack_ctl_t           stk_ctl;
  logic [DIGIT_W-1:0]   stk_top;
  logic [COUNT_W-1:0]   stk_count;

  logic                 acc;
  logic                 kind_ok;
  logic                 neg_in;
  radix_t               radix_in;
  logic [WIDTH_W-1:0]   width_in;

  logic                 neg;
  logic                 is_char;
  logic                 left;
  logic                 zero_pad;
  logic [WIDTH_W-1:0]   width_sat;
  logic [WIDTH_W-1:0]   pad;
  logic [CHAR_W-1:0]    char_byte;

  logic [WIDTH_W-1:0]   len;
  logic [WIDTH_W-1:0]   pad_calc;
  logic                 tail;
  logic [CHAR_W-1:0]    pad_char;

  logic                 emit_ok;
  logic                 emit;
  logic [CHAR_W-1:0]    emit_char;
  logic                 emit_last;

  logic                 out_valid;
  logic [CHAR_W-1:0]    out_char;
  logic                 out_last;

  ptt_digit_unit u_digit (
    .clk (clk),
    .rst (rst),
    .req (dig_req),
    .rsp (dig_rsp)
  );

  ptt_stack u_stack (
    .clk   (clk),
    .rst   (rst),
    .ctl   (stk_ctl),
    .top   (stk_top),
    .count (stk_count)
  );

  assign operand.ready  = (state == ST_IDLE);
  assign acc            = operand.valid && operand.ready;
  assign kind_ok        = (operand.kind <= KIND_CHAR);
  assign neg_in         = (operand.kind == KIND_SDEC) && operand.value[VALUE_W-1];
  assign width_in       = (operand.field_width > WIDTH_W'(MAX_WIDTH)) ?
                          WIDTH_W'(MAX_WIDTH) : operand.field_width;

  always_comb begin
    case (operand.kind)
      KIND_HEX: radix_in = RADIX_HEX;
      KIND_OCT: radix_in = RADIX_OCT;
      KIND_BIN: radix_in = RADIX_BIN;
      default:  radix_in = RADIX_DEC;
    endcase
  end

  assign dig_req.start = acc && kind_ok && (operand.kind != KIND_CHAR);
  assign dig_req.radix = radix_in;
  assign dig_req.mag   = neg_in ? (VALUE_W'(0) - operand.value) : operand.value;

  assign len      = is_char ? WIDTH_W'(1) : (WIDTH_W'(stk_count) + WIDTH_W'(neg));
  assign pad_calc = (width_sat > len) ? (width_sat - len) : '0;
  assign tail     = left && (pad != '0);
  assign pad_char = zero_pad ? CHAR_ZERO : CHAR_SPACE;
  assign emit_ok  = !out_valid || text.ready;

  always_comb begin
    if (is_char) begin
      first_text = ST_CHAR;
    end else if (neg) begin
      first_text = ST_SIGN;
    end else begin
      first_text = ST_DIGITS;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc && kind_ok) begin
          state_next = (operand.kind == KIND_CHAR) ? ST_PREP : ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (dig_rsp.valid && dig_rsp.last) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = (!left && (pad_calc != '0)) ? ST_PAD_LEAD : first_text;
      end
      ST_PAD_LEAD: begin
        if (emit_ok && (pad == WIDTH_W'(1))) begin
          state_next = first_text;
        end
      end
      ST_SIGN: begin
        if (emit_ok) begin
          state_next = ST_DIGITS;
        end
      end
      ST_CHAR: begin
        if (emit_ok) begin
          state_next = tail ? ST_PAD_TRAIL : ST_IDLE;
        end
      end
      ST_DIGITS: begin
        if (emit_ok && (stk_count == COUNT_W'(1))) begin
          state_next = tail ? ST_PAD_TRAIL : ST_IDLE;
        end
      end
      ST_PAD_TRAIL: begin
        if (emit_ok && (pad == WIDTH_W'(1))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    emit          = 1'b0;
    emit_char     = pad_char;
    emit_last     = 1'b0;
    stk_ctl.push  = 1'b0;
    stk_ctl.pop   = 1'b0;
    stk_ctl.digit = dig_rsp.digit;
    unique case (state)
      ST_CONVERT: begin
        stk_ctl.push = dig_rsp.valid;
      end
      ST_PAD_LEAD: begin
        emit = emit_ok;
      end
      ST_SIGN: begin
        emit      = emit_ok;
        emit_char = CHAR_MINUS;
      end
      ST_CHAR: begin
        emit      = emit_ok;
        emit_char = char_byte;
        emit_last = !tail;
      end
      ST_DIGITS: begin
        emit        = emit_ok;
        emit_char   = digit_char(stk_top);
        emit_last   = (stk_count == COUNT_W'(1)) && !tail;
        stk_ctl.pop = emit_ok;
      end
      ST_PAD_TRAIL: begin
        emit      = emit_ok;
        emit_last = (pad == WIDTH_W'(1));
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      neg       <= neg_in;
      is_char   <= (operand.kind == KIND_CHAR);
      left      <= operand.align_left;
      zero_pad  <= operand.pad_with_zero;
      width_sat <= width_in;
      char_byte <= operand.value[CHAR_W-1:0];
    end
    if (state == ST_PREP) begin
      pad <= pad_calc;
    end else if (emit && ((state == ST_PAD_LEAD) || (state == ST_PAD_TRAIL))) begin
      pad <= pad - WIDTH_W'(1);
    end
    if (emit) begin
      out_char <= emit_char;
      out_last <= emit_last;
    end
  end

  assign text.valid     = out_valid;
  assign text.text_char = out_char;
  assign text.last_char = out_last;

  `PTT_ASSERT_SAME(a_stack_room, stk_ctl.push, stk_count < COUNT_W'(DIGITS_MAX), "digit stack overflow")
  `PTT_ASSERT_SAME(a_digits_present, state == ST_DIGITS, stk_count != '0, "digit state with empty stack")
  `PTT_ASSERT_NEXT(a_bad_kind_idle, acc && !kind_ok, state == ST_IDLE, "unsupported kind left idle")
  `PTT_ASSERT_NEXT(a_last_ends_item, emit && emit_last, state == ST_IDLE, "last character did not end item")

endmodule
